@@ design/msl_pkg.sv @@
// Shared types, widths and codes for the master/stack tile layout block.
// No dependencies; every other file imports this package.
`default_nettype none

package msl_pkg;

  // Largest number of tiles one request may produce.
  localparam int MAX_WINDOWS = 32;

  // Field widths.
  localparam int PAD_W  = 10;
  localparam int GAP_W  = 10;
  localparam int BOR_W  = 8;
  localparam int AXY_W  = 16;
  localparam int ASZ_W  = 15;
  localparam int CNT_W  = 6;
  localparam int SPL_W  = 9;
  localparam int TIDX_W = 5;
  localparam int TXY_W  = 17;
  localparam int TSZ_W  = 15;

  // Internal signed coordinate width; wide enough for running stack sizes.
  localparam int CW = 20;

  // Divisor width of the serial divider.
  localparam int DIVR_W = CNT_W;

  // Split ratio is Q1.8.
  localparam int SPLIT_FRAC = 8;
  localparam int SPLIT_ONE  = 256;

  // Register port.
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef enum logic [1:0] {
    REG_OUTER_PADDING = 2'd0,
    REG_GAP_MARGIN    = 2'd1,
    REG_BORDER_WIDTH  = 2'd2
  } msl_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_START,
    ST_WAIT,
    ST_EMIT
  } msl_state_t;

  typedef struct packed {
    logic [PAD_W-1:0] outer_padding;
    logic [GAP_W-1:0] gap_margin;
    logic [BOR_W-1:0] border_width;
  } msl_cfg_t;

  typedef struct packed {
    logic load;
    logic init;
    logic start_div;
    logic emit;
  } msl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic div_done;
    logic last;
    logic out_free;
  } msl_stat_t;

endpackage

`default_nettype wire

@@ design/msl_if.sv @@
// Request and tile channel interfaces for the master/stack tile layout block.
// Depends on msl_pkg.
`default_nettype none

interface msl_in_if;
  import msl_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [AXY_W-1:0] area_x;
  logic signed [AXY_W-1:0] area_y;
  logic [ASZ_W-1:0]        area_width;
  logic [ASZ_W-1:0]        area_height;
  logic [CNT_W-1:0]        window_count;
  logic [CNT_W-1:0]        main_depth;
  logic [SPL_W-1:0]        split_ratio;

  modport source (
    output valid, area_x, area_y, area_width, area_height, window_count, main_depth,
           split_ratio,
    input  ready
  );
  modport sink (
    input  valid, area_x, area_y, area_width, area_height, window_count, main_depth,
           split_ratio,
    output ready
  );
endinterface

interface msl_out_if;
  import msl_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [TIDX_W-1:0]       window_index;
  logic signed [TXY_W-1:0] tile_x;
  logic signed [TXY_W-1:0] tile_y;
  logic [TSZ_W-1:0]        tile_width;
  logic [TSZ_W-1:0]        tile_height;
  logic                    last_tile;

  modport source (
    output valid, window_index, tile_x, tile_y, tile_width, tile_height, last_tile,
    input  ready
  );
  modport sink (
    input  valid, window_index, tile_x, tile_y, tile_width, tile_height, last_tile,
    output ready
  );
endinterface

`default_nettype wire

@@ design/msl_cfg.sv @@
// Configuration register file with an APB-style write/read port.
// Depends on msl_pkg.
`default_nettype none

module msl_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [msl_pkg::APB_AW-1:0] paddr,
  input  logic [msl_pkg::APB_DW-1:0] pwdata,
  output logic [msl_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  output msl_pkg::msl_cfg_t         cfg
);
  import msl_pkg::*;

  msl_cfg_t cfg_r;
  msl_cfg_t cfg_nxt;
  msl_reg_t reg_sel;
  logic     wr_en;

  assign reg_sel = msl_reg_t'(paddr[APB_AW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        REG_OUTER_PADDING: cfg_nxt.outer_padding = pwdata[PAD_W-1:0];
        REG_GAP_MARGIN:    cfg_nxt.gap_margin    = pwdata[GAP_W-1:0];
        REG_BORDER_WIDTH:  cfg_nxt.border_width  = pwdata[BOR_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_OUTER_PADDING: prdata = {{(APB_DW-PAD_W){1'b0}}, cfg_r.outer_padding};
      REG_GAP_MARGIN:    prdata = {{(APB_DW-GAP_W){1'b0}}, cfg_r.gap_margin};
      REG_BORDER_WIDTH:  prdata = {{(APB_DW-BOR_W){1'b0}}, cfg_r.border_width};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/msl_div.sv @@
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on msl_pkg.
`default_nettype none

module msl_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [msl_pkg::CW-1:0] dividend,
  input  logic [msl_pkg::DIVR_W-1:0]  divisor,
  output logic                        done,
  output logic signed [msl_pkg::CW-1:0] quotient
);
  import msl_pkg::*;

  localparam int STEP_W = $clog2(CW);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [CW-1:0]     mag_r;
  logic [DIVR_W-1:0] rem_r;
  logic [DIVR_W-1:0] dvs_r;
  logic              neg_r;
  logic [DIVR_W:0]   rem_sh;
  logic [DIVR_W:0]   rem_sub;
  logic              fits;

  // The magnitude register shifts the dividend out at the top while the
  // quotient bits shift in at the bottom.
  assign rem_sh  = {rem_r, mag_r[CW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign fits    = (rem_sh >= {1'b0, dvs_r});

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(mag_r) : $signed(mag_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
      end else if (busy_r && (step_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r  <= dividend[CW-1] ? CW'(-dividend) : CW'(dividend);
      neg_r  <= dividend[CW-1];
      dvs_r  <= divisor;
      rem_r  <= '0;
      step_r <= STEP_W'(CW - 1);
    end else if (busy_r) begin
      mag_r  <= {mag_r[CW-2:0], fits};
      rem_r  <= fits ? rem_sub[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
      step_r <= step_r - STEP_W'(1);
    end
  end

endmodule

`default_nettype wire

@@ design/msl_datapath.sv @@
// Layout datapath: request registers, running column sizes, tile arithmetic
// and the output register. Depends on msl_pkg and msl_div.
`default_nettype none

module msl_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  msl_pkg::msl_cmd_t             cmd,
  output msl_pkg::msl_stat_t            stat,
  input  msl_pkg::msl_cfg_t             cfg,
  input  logic signed [msl_pkg::AXY_W-1:0] area_x,
  input  logic signed [msl_pkg::AXY_W-1:0] area_y,
  input  logic [msl_pkg::ASZ_W-1:0]     area_width,
  input  logic [msl_pkg::ASZ_W-1:0]     area_height,
  input  logic [msl_pkg::CNT_W-1:0]     window_count,
  input  logic [msl_pkg::CNT_W-1:0]     main_depth,
  input  logic [msl_pkg::SPL_W-1:0]     split_ratio,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [msl_pkg::TIDX_W-1:0]    window_index,
  output logic signed [msl_pkg::TXY_W-1:0] tile_x,
  output logic signed [msl_pkg::TXY_W-1:0] tile_y,
  output logic [msl_pkg::TSZ_W-1:0]     tile_width,
  output logic [msl_pkg::TSZ_W-1:0]     tile_height,
  output logic                          last_tile
);
  import msl_pkg::*;

  // Request registers.
  logic signed [CW-1:0] bx_r, by_r;
  logic [ASZ_W-1:0]     bw_r, bh_r;
  logic [CNT_W-1:0]     count_r, depth_r, cur_depth_r;
  logic [SPL_W-1:0]     split_r;
  logic [ASZ_W-1:0]     mainw_r;

  // Running state across tiles.
  logic signed [CW-1:0] stackh_r, stackh_nxt;
  logic signed [CW-1:0] rightw_r, rightw_nxt;
  logic [CNT_W-1:0]     w_r;

  // Output register.
  logic                    out_valid_r;
  logic [TIDX_W-1:0]       idx_r;
  logic signed [TXY_W-1:0] tx_r, ty_r;
  logic [TSZ_W-1:0]        tw_r, th_r;
  logic                    last_r;

  logic signed [CW-1:0]       bx_in, by_in, bw_in, bh_in;
  logic [CNT_W-1:0]           count_in, depth_in;
  logic [SPL_W-1:0]           split_in;
  logic [ASZ_W+SPL_W-1:0]     prod;
  logic                       in_main;
  logic [DIVR_W-1:0]          divisor;
  logic signed [CW-1:0]       quo;
  logic                       div_done;
  logic signed [CW-1:0]       bw_ext, bh_ext, gap_ext, bor_ext, bor2;
  logic signed [CW-1:0]       tx, ty, tw, th;
  logic signed [CW-1:0]       tx_b, ty_b, tw_b, th_b;
  logic                       last;

  // Request intake: padding, clamps and saturations.
  assign bx_in = $signed({{(CW-AXY_W){area_x[AXY_W-1]}}, area_x})
               + $signed({{(CW-PAD_W){1'b0}}, cfg.outer_padding});
  assign by_in = $signed({{(CW-AXY_W){area_y[AXY_W-1]}}, area_y})
               + $signed({{(CW-PAD_W){1'b0}}, cfg.outer_padding});
  assign bw_in = $signed({{(CW-ASZ_W){1'b0}}, area_width})
               - $signed({{(CW-PAD_W-1){1'b0}}, cfg.outer_padding, 1'b0});
  assign bh_in = $signed({{(CW-ASZ_W){1'b0}}, area_height})
               - $signed({{(CW-PAD_W-1){1'b0}}, cfg.outer_padding, 1'b0});
  assign count_in = (window_count > CNT_W'(MAX_WINDOWS)) ? CNT_W'(MAX_WINDOWS) : window_count;
  assign depth_in = (main_depth == '0) ? CNT_W'(1) : main_depth;
  assign split_in = (split_ratio > SPL_W'(SPLIT_ONE)) ? SPL_W'(SPLIT_ONE) : split_ratio;

  assign prod = ASZ_W'(bw_r) * split_r;

  // Per-tile geometry.
  assign bw_ext  = $signed({{(CW-ASZ_W){1'b0}}, bw_r});
  assign bh_ext  = $signed({{(CW-ASZ_W){1'b0}}, bh_r});
  assign gap_ext = $signed({{(CW-GAP_W){1'b0}}, cfg.gap_margin});
  assign bor_ext = $signed({{(CW-BOR_W){1'b0}}, cfg.border_width});
  assign bor2    = $signed({{(CW-BOR_W-1){1'b0}}, cfg.border_width, 1'b0});

  assign in_main = (w_r < depth_r);
  assign divisor = in_main ? (cur_depth_r - w_r) : (count_r - w_r);
  assign tx      = in_main ? bx_r : (bx_r + bw_ext - rightw_r);
  assign tw      = in_main ? $signed({{(CW-ASZ_W){1'b0}}, mainw_r}) : rightw_r;
  assign ty      = by_r + bh_ext - stackh_r;
  assign th      = quo;
  assign last    = (w_r == (count_r - CNT_W'(1)));

  assign tx_b = tx + bor_ext;
  assign ty_b = ty + bor_ext;
  assign tw_b = tw - bor2;
  assign th_b = th - bor2;

  msl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start_div),
    .dividend (stackh_r),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    stackh_nxt = stackh_r - th - gap_ext;
    rightw_nxt = rightw_r;
    if (w_r == (depth_r - CNT_W'(1))) begin
      rightw_nxt = rightw_r - tw - gap_ext;
      stackh_nxt = bh_ext;
    end
  end

  assign stat.count_zero = (count_r == '0);
  assign stat.div_done   = div_done;
  assign stat.last       = last;
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign window_index = idx_r;
  assign tile_x       = tx_r;
  assign tile_y       = ty_r;
  assign tile_width   = tw_r;
  assign tile_height  = th_r;
  assign last_tile    = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bx_r    <= bx_in;
      by_r    <= by_in;
      bw_r    <= bw_in[CW-1] ? '0 : bw_in[ASZ_W-1:0];
      bh_r    <= bh_in[CW-1] ? '0 : bh_in[ASZ_W-1:0];
      count_r <= count_in;
      depth_r <= depth_in;
      split_r <= split_in;
    end
    if (cmd.init) begin
      mainw_r     <= (count_r > depth_r) ? prod[ASZ_W+SPLIT_FRAC-1:SPLIT_FRAC] : bw_r;
      cur_depth_r <= (count_r < depth_r) ? count_r : depth_r;
      stackh_r    <= bh_ext;
      rightw_r    <= bw_ext;
      w_r         <= '0;
    end else if (cmd.emit) begin
      stackh_r <= stackh_nxt;
      rightw_r <= rightw_nxt;
      w_r      <= w_r + CNT_W'(1);
    end
    if (cmd.emit) begin
      idx_r  <= w_r[TIDX_W-1:0];
      tx_r   <= tx_b[TXY_W-1:0];
      ty_r   <= ty_b[TXY_W-1:0];
      tw_r   <= tw_b[CW-1] ? '0 : tw_b[TSZ_W-1:0];
      th_r   <= th_b[CW-1] ? '0 : th_b[TSZ_W-1:0];
      last_r <= last;
    end
  end

  // A tile is only produced for a window that exists.
  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (w_r < count_r))
    else $error("tile emitted beyond the window count");

  // The stack and column divisors are never zero.
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_div |-> (divisor != '0))
    else $error("division started with a zero divisor");

endmodule

`default_nettype wire

@@ design/msl_ctrl.sv @@
// Controller state machine: sequences request intake, one divide per tile
// and the hand-off of each tile to the output register. Depends on msl_pkg.
`default_nettype none

module msl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  msl_pkg::msl_stat_t stat,
  output msl_pkg::msl_cmd_t  cmd
);
  import msl_pkg::*;

  msl_state_t state_r;
  msl_state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = stat.count_zero ? ST_IDLE : ST_START;
      ST_START: state_nxt = ST_WAIT;
      ST_WAIT:  if (stat.div_done) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (stat.out_free) begin
          state_nxt = stat.last ? ST_IDLE : ST_START;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SETUP: cmd.init      = 1'b1;
      ST_START: cmd.start_div = 1'b1;
      ST_EMIT:  cmd.emit      = stat.out_free;
      default:  cmd           = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Handing off the final tile ends the request.
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && stat.last) |=> (state_r == ST_IDLE))
    else $error("controller did not return to idle after the last tile");

  // The divider only finishes while the controller waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> (state_r == ST_WAIT))
    else $error("divider finished outside the wait state");

endmodule

`default_nettype wire

@@ design/master_stack_tile_layout.sv @@
// Top level of the master/stack tile layout block: register file,
// controller and datapath. Depends on msl_pkg, msl_if, msl_cfg, msl_ctrl, msl_datapath.
//
//   Port group   Direction  Handshake             Beat
//   in_ch        sink       valid/ready           one layout request
//   out_ch       source     valid/ready           one tile rectangle
//   psel...      slave      APB setup + access    one register write or read
//
// A request is taken in and set up; then each tile in turn starts the
// divide, waits on the serial divider (20 quotient bits at one per cycle,
// then its done flag is seen) and is handed to the output register. A
// request of zero windows is set up and produces no beat.
// Reset is synchronous and active low; it clears the configuration registers,
// the valid and divider flags and returns the controller to idle; no clearing pass.
// A stalled result channel holds the finished tile in the output register;
// the controller waits with the next tile's quotient until the slot frees.
// A new request is accepted as soon as the last tile is in the output
// register, even while that tile still waits to be taken.
`default_nettype none

module master_stack_tile_layout (
  input  logic                       clk,
  input  logic                       rst_n,
  msl_in_if.sink                     in_ch,
  msl_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [msl_pkg::APB_AW-1:0] paddr,
  input  logic [msl_pkg::APB_DW-1:0] pwdata,
  output logic [msl_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import msl_pkg::*;

  msl_cfg_t  cfg;
  msl_cmd_t  cmd;
  msl_stat_t stat;

  // Register file; to be written only while the block is idle, which it does not itself enforce.
  msl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer for intake, per-tile divide and tile hand-off.
  msl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Geometry, the serial divider and the output register.
  msl_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .cfg          (cfg),
    .area_x       (in_ch.area_x),
    .area_y       (in_ch.area_y),
    .area_width   (in_ch.area_width),
    .area_height  (in_ch.area_height),
    .window_count (in_ch.window_count),
    .main_depth   (in_ch.main_depth),
    .split_ratio  (in_ch.split_ratio),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .window_index (out_ch.window_index),
    .tile_x       (out_ch.tile_x),
    .tile_y       (out_ch.tile_y),
    .tile_width   (out_ch.tile_width),
    .tile_height  (out_ch.tile_height),
    .last_tile    (out_ch.last_tile)
  );

endmodule

`default_nettype wire

@@ bench/master_stack_tile_layout_test.sv @@
// Self-checking bench for the master/stack tile layout block.
// Depends on msl_pkg, msl_if and the master_stack_tile_layout RTL.
module master_stack_tile_layout_test;
  import msl_pkg::*;

  // Address slot just past the last register; writes there must be dropped.
  localparam logic [1:0] REG_SPARE = 2'd3;

  // Quiet cycles after the last tile; enough for a pending zero-window request
  // to finish, so that the block is then idle.
  localparam int SETTLE_CYCLES   = 30;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 25;
  localparam int DIR_ROWS        = 20;

  // One layout request, laid out as the input channel carries it.
  typedef struct packed {
    logic [AXY_W-1:0] area_x;
    logic [AXY_W-1:0] area_y;
    logic [ASZ_W-1:0] area_width;
    logic [ASZ_W-1:0] area_height;
    logic [CNT_W-1:0] window_count;
    logic [CNT_W-1:0] main_depth;
    logic [SPL_W-1:0] split_ratio;
  } layout_req_t;

  // One tile beat as the result channel carries it.
  typedef struct packed {
    logic [TIDX_W-1:0] idx;
    logic [TXY_W-1:0]  x;
    logic [TXY_W-1:0]  y;
    logic [TSZ_W-1:0]  w;
    logic [TSZ_W-1:0]  h;
    logic              last;
  } tile_t;

  // A directed row: the register setting it runs under, the request, and
  // either a single tile typed in by hand (typed = 1), no tile at all
  // (typed = 0), or a request left to the predictor (typed = -1).
  typedef struct {
    int          pad;
    int          gap;
    int          bor;
    layout_req_t req;
    int          typed;
    tile_t       tile;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  msl_in_if  in_ch ();
  msl_out_if out_ch ();

  master_stack_tile_layout i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // The bench's own copy of the layout registers; it follows every write.
  logic [PAD_W-1:0] cfg_pad = '0;
  logic [GAP_W-1:0] cfg_gap = '0;
  logic [BOR_W-1:0] cfg_bor = '0;

  // Tiles that accepted requests still owe, oldest first.
  tile_t    tiles_due[$];
  dir_row_t dir_tab[DIR_ROWS];
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;
  bit       failed         = 1'b0;

  function automatic dir_row_t dir_entry(input int pad, gap, bor, ax, ay, aw, ah,
                                         cnt, dep, spl, typed, tx, ty, tw, th);
    dir_row_t d;
    d.pad                = pad;
    d.gap                = gap;
    d.bor                = bor;
    d.req.area_x         = ax[AXY_W-1:0];
    d.req.area_y         = ay[AXY_W-1:0];
    d.req.area_width     = aw[ASZ_W-1:0];
    d.req.area_height    = ah[ASZ_W-1:0];
    d.req.window_count   = cnt[CNT_W-1:0];
    d.req.main_depth     = dep[CNT_W-1:0];
    d.req.split_ratio    = spl[SPL_W-1:0];
    d.typed              = typed;
    d.tile.idx           = '0;
    d.tile.x             = tx[TXY_W-1:0];
    d.tile.y             = ty[TXY_W-1:0];
    d.tile.w             = tw[TSZ_W-1:0];
    d.tile.h             = th[TSZ_W-1:0];
    d.tile.last          = 1'b1;
    return d;
  endfunction

  // Works out every tile of one request under the current registers and
  // queues them. All arithmetic runs at 64 bits so that running stack sizes
  // may go negative, exactly as the block is specified to let them.
  function automatic void predict_tiles(input layout_req_t r);
    longint pad, gap, bor, bx, by, bw, bh, cnt, dep, spl, cur, rightw, stackh;
    longint w, tx, ty, tw, th, fw, fh, px, py;
    tile_t  t;
    pad = cfg_pad;
    gap = cfg_gap;
    bor = cfg_bor;
    // Shrink the area by the outer padding; the size clamps at zero.
    bx  = longint'($signed(r.area_x)) + pad;
    by  = longint'($signed(r.area_y)) + pad;
    bw  = longint'(r.area_width) - 2 * pad;
    bh  = longint'(r.area_height) - 2 * pad;
    cnt = r.window_count;
    dep = r.main_depth;
    spl = r.split_ratio;
    if (bw < 0) bw = 0;
    if (bh < 0) bh = 0;
    if (cnt > MAX_WINDOWS) cnt = MAX_WINDOWS;
    if (dep < 1) dep = 1;
    if (spl > SPLIT_ONE) spl = SPLIT_ONE;
    cur    = (cnt < dep) ? cnt : dep;
    rightw = bw;
    stackh = bh;
    for (w = 0; w < cnt; w++) begin
      if (w < dep) begin
        // Main column; it only gives up width when the stack is in use.
        tx = bx;
        tw = bw;
        th = stackh / (cur - w);
        if (cnt > dep) tw = (tw * spl) >>> SPLIT_FRAC;
      end else begin
        tx = bx + bw - rightw;
        tw = rightw;
        th = stackh / (cnt - w);
      end
      ty     = by + bh - stackh;
      stackh -= th + gap;
      if (w == dep - 1) begin
        // The main column is full: the stack starts over at the top.
        rightw -= tw + gap;
        stackh = bh;
      end
      fw = tw - 2 * bor;
      fh = th - 2 * bor;
      if (fw < 0) fw = 0;
      if (fh < 0) fh = 0;
      px     = tx + bor;
      py     = ty + bor;
      t.idx  = w[TIDX_W-1:0];
      t.x    = px[TXY_W-1:0];
      t.y    = py[TXY_W-1:0];
      t.w    = fw[TSZ_W-1:0];
      t.h    = fh[TSZ_W-1:0];
      t.last = (w == cnt - 1);
      tiles_due.push_back(t);
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  // Result monitor: every accepted tile beat is checked against the oldest
  // tile still owed.
  always @(posedge clk) begin
    tile_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.window_index, out_ch.tile_x, out_ch.tile_y,
             out_ch.tile_width, out_ch.tile_height, out_ch.last_tile};
      if (tiles_due.size() == 0) begin
        $display("%0t: tile beat with nothing pending: expected none, got %h", $time, got);
        failed = 1'b1;
      end else begin
        want = tiles_due.pop_front();
        check_field("window_index", want.idx, got.idx);
        check_field("tile_x", want.x, got.x);
        check_field("tile_y", want.y, got.y);
        check_field("tile_width", want.w, got.w);
        check_field("tile_height", want.h, got.h);
        check_field("last_tile", want.last, got.last);
      end
    end
  end

  // The receiver stalls at random; with a rate of zero it is always ready.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // One register access: setup cycle, then access cycle until pready.
  task automatic apb_access(input bit wr, input logic [1:0] idx,
                            input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_readback(input msl_reg_t idx, input logic [APB_DW-1:0] want);
    logic [APB_DW-1:0] rd;
    apb_access(1'b0, idx, '0, rd);
    check_field(idx.name(), want, rd);
  endtask

  // Writes all three registers with junk above their widths, then a junk
  // write to the spare slot, and reads the three registers back.
  task automatic load_layout_config(input int pad, gap, bor);
    logic [APB_DW-1:0] wd, rd;
    wd = $urandom();
    wd[PAD_W-1:0] = pad[PAD_W-1:0];
    apb_access(1'b1, REG_OUTER_PADDING, wd, rd);
    wd = $urandom();
    wd[GAP_W-1:0] = gap[GAP_W-1:0];
    apb_access(1'b1, REG_GAP_MARGIN, wd, rd);
    wd = $urandom();
    wd[BOR_W-1:0] = bor[BOR_W-1:0];
    apb_access(1'b1, REG_BORDER_WIDTH, wd, rd);
    apb_access(1'b1, REG_SPARE, $urandom(), rd);
    cfg_pad = pad[PAD_W-1:0];
    cfg_gap = gap[GAP_W-1:0];
    cfg_bor = bor[BOR_W-1:0];
    reg_readback(REG_OUTER_PADDING, {{(APB_DW-PAD_W){1'b0}}, cfg_pad});
    reg_readback(REG_GAP_MARGIN, {{(APB_DW-GAP_W){1'b0}}, cfg_gap});
    reg_readback(REG_BORDER_WIDTH, {{(APB_DW-BOR_W){1'b0}}, cfg_bor});
  endtask

  // Offers one request beat, idling first at random, and returns at the
  // rising edge that accepts it. Valid stays high on return so that a
  // following request can go out back to back.
  task automatic send_request(input layout_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.area_x       <= r.area_x;
    in_ch.area_y       <= r.area_y;
    in_ch.area_width   <= r.area_width;
    in_ch.area_height  <= r.area_height;
    in_ch.window_count <= r.window_count;
    in_ch.main_depth   <= r.main_depth;
    in_ch.split_ratio  <= r.split_ratio;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stops offering requests, waits for every owed tile, then lets the
  // block finish any request that produces no tile.
  task automatic settle_block();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tiles_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Most requests are ordinary layouts with a handful of windows; some have 9
  // windows up to the full tile budget, and the rest draw count, depth and split
  // over their full widths so the saturating and flooring paths are exercised.
  function automatic layout_req_t random_request();
    layout_req_t r;
    int          v, kind;
    v = $urandom();
    r.area_x = v[15:0];
    r.area_y = v[31:16];
    v = $urandom();
    if ($urandom_range(3) == 0) begin
      r.area_width  = ASZ_W'($urandom_range(200));
      r.area_height = ASZ_W'($urandom_range(200));
    end else begin
      r.area_width  = v[ASZ_W-1:0];
      r.area_height = v[ASZ_W+15:16];
    end
    kind = $urandom_range(99);
    if (kind < 70) begin
      v = $urandom_range(8, 1);
      r.window_count = v[CNT_W-1:0];
      v = $urandom_range(4, 1);
      r.main_depth = v[CNT_W-1:0];
      v = $urandom_range(SPLIT_ONE);
      r.split_ratio = v[SPL_W-1:0];
    end else if (kind < 85) begin
      v = $urandom_range(MAX_WINDOWS, 9);
      r.window_count = v[CNT_W-1:0];
      v = $urandom_range(MAX_WINDOWS, 1);
      r.main_depth = v[CNT_W-1:0];
      v = $urandom_range(SPLIT_ONE);
      r.split_ratio = v[SPL_W-1:0];
    end else begin
      v = $urandom();
      r.window_count = v[CNT_W-1:0];
      r.main_depth   = v[CNT_W+7:8];
      r.split_ratio  = v[SPL_W+15:16];
    end
    return r;
  endfunction

  initial begin
    layout_req_t r;
    int          mode;

    // Every input of the block is known from time zero.
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_ch.valid        = 1'b0;
    in_ch.area_x       = '0;
    in_ch.area_y       = '0;
    in_ch.area_width   = '0;
    in_ch.area_height  = '0;
    in_ch.window_count = '0;
    in_ch.main_depth   = '0;
    in_ch.split_ratio  = '0;
    out_ch.ready       = 1'b1;

    // Directed table. Columns: pad, gap, border, x, y, width, height,
    // count, depth, split, typed, and the hand-computed tile where typed.
    // Under the reset registers: one plain tile, an empty request, both
    // corner extremes, a floored depth and an oversized split.
    dir_tab[0]  = dir_entry(0, 0, 0, 0, 0, 100, 50, 1, 1, 128, 1, 0, 0, 100, 50);
    dir_tab[1]  = dir_entry(0, 0, 0, 5, 5, 100, 50, 0, 1, 128, 0, 0, 0, 0, 0);
    dir_tab[2]  = dir_entry(0, 0, 0, -32768, -32768, 32767, 32767, 1, 1, 0,
                            1, -32768, -32768, 32767, 32767);
    dir_tab[3]  = dir_entry(0, 0, 0, 32767, 32767, 0, 0, 1, 0, 511,
                            1, 32767, 32767, 0, 0);
    // Main column plus stack, depth beyond count, full budgets, saturation.
    dir_tab[4]  = dir_entry(0, 0, 0, 0, 0, 100, 40, 2, 1, 128, -1, 0, 0, 0, 0);
    dir_tab[5]  = dir_entry(0, 0, 0, -100, 200, 1920, 1080, 5, 2, 200, -1, 0, 0, 0, 0);
    dir_tab[6]  = dir_entry(0, 0, 0, 0, 0, 1000, 900, 3, 5, 128, -1, 0, 0, 0, 0);
    dir_tab[7]  = dir_entry(0, 0, 0, 0, 0, 32767, 32767, 32, 1, 256, -1, 0, 0, 0, 0);
    dir_tab[8]  = dir_entry(0, 0, 0, 0, 0, 32767, 32767, 32, 32, 0, -1, 0, 0, 0, 0);
    dir_tab[9]  = dir_entry(0, 0, 0, 10, 10, 500, 500, 63, 63, 300, -1, 0, 0, 0, 0);
    dir_tab[10] = dir_entry(0, 0, 0, 0, 0, 640, 480, 33, 0, 257, -1, 0, 0, 0, 0);
    dir_tab[11] = dir_entry(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[12] = dir_entry(0, 0, 0, -1, -1, 32767, 32767, 63, 63, 511, -1, 0, 0, 0, 0);
    // Padding larger than the area collapses it to a point at the corner.
    dir_tab[13] = dir_entry(1023, 0, 0, 0, 0, 100, 100, 1, 1, 128, 1, 1023, 1023, 0, 0);
    dir_tab[14] = dir_entry(1023, 0, 0, -32768, -32768, 32767, 32767, 4, 2, 64,
                            -1, 0, 0, 0, 0);
    // A border wider than the tile clamps its size at zero.
    dir_tab[15] = dir_entry(0, 0, 255, 0, 0, 100, 100, 1, 1, 128, 1, 255, 255, 0, 0);
    dir_tab[16] = dir_entry(0, 0, 255, 0, 0, 32767, 32767, 3, 1, 128, -1, 0, 0, 0, 0);
    // Gaps that outgrow the space drive the running stack height negative.
    dir_tab[17] = dir_entry(0, 1023, 0, 0, 0, 200, 100, 8, 2, 128, -1, 0, 0, 0, 0);
    // All registers at their top: the stack corner wraps past 17 bits.
    dir_tab[18] = dir_entry(1023, 1023, 255, 32767, 32767, 32767, 32767, 2, 1, 256,
                            -1, 0, 0, 0, 0);
    dir_tab[19] = dir_entry(1023, 1023, 255, -32768, -32768, 0, 0, 32, 4, 256,
                            -1, 0, 0, 0, 0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. The registers are only rewritten when a row asks for a
    // different setting, and only once the block has gone idle; the first
    // rows therefore run on the reset values.
    send_idle_pct  = 24;
    recv_stall_pct = 24;
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].pad != cfg_pad || dir_tab[i].gap != cfg_gap ||
          dir_tab[i].bor != cfg_bor) begin
        settle_block();
        load_layout_config(dir_tab[i].pad, dir_tab[i].gap, dir_tab[i].bor);
      end
      send_request(dir_tab[i].req);
      if (dir_tab[i].typed == 1) begin
        tiles_due.push_back(dir_tab[i].tile);
      end else if (dir_tab[i].typed < 0) begin
        predict_tiles(dir_tab[i].req);
      end
    end

    // Random part. Each phase settles the block, picks a register setting
    // (the extremes among them) and a flow-control pattern, then streams
    // random requests through the predictor.
    for (int p = 0; p < PHASES; p++) begin
      settle_block();
      case (p)
        0: begin
          load_layout_config(0, 0, 0);
        end
        1: begin
          load_layout_config(1023, 1023, 255);
        end
        2: begin
          load_layout_config(4, 2, 1);
        end
        4: begin
          load_layout_config(0, 1023, 0);
        end
        5: begin
          load_layout_config($urandom_range(16), $urandom_range(16), $urandom_range(8));
        end
        6: begin
          load_layout_config(1023, 0, 255);
        end
        default: begin
          load_layout_config($urandom_range(1023), $urandom_range(1023),
                             $urandom_range(255));
        end
      endcase
      // Flow control cycles through: none, sender gaps, receiver stalls, both.
      mode           = p % 4;
      send_idle_pct  = (mode == 1) ? 47 : (mode == 3) ? 24 : 0;
      recv_stall_pct = (mode == 2) ? 47 : (mode == 3) ? 24 : 0;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        r = random_request();
        send_request(r);
        predict_tiles(r);
      end
    end

    settle_block();
    if (failed) begin
      $display("Test completed with failures");
    end else begin
      $display("Test completed successfully");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of every request at the full
  // tile budget under heavy stalls.
  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ files.f @@
design/msl_pkg.sv
design/msl_if.sv
design/msl_cfg.sv
design/msl_div.sv
design/msl_datapath.sv
design/msl_ctrl.sv
design/master_stack_tile_layout.sv
bench/master_stack_tile_layout_test.sv
